@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker i2a_chk.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/core/i2a_pkg.sv @@
// Types, constants and helper functions of the integer to ASCII formatter.
// No dependencies; imported by the formatter modules, the checkers and the testbench.
package i2a_pkg;

  typedef enum logic [1:0] {
    CMD_DEC  = 2'd0,
    CMD_HEX  = 2'd1,
    CMD_HEX8 = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned DD_STAGES  = 8;
  localparam int unsigned DD_BITS    = WORD_W / DD_STAGES;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_LOW_A = 8'h61;
  localparam logic [7:0] CHR_UP_A  = 8'h41;

  // Item inside the conversion pipe
  typedef struct packed {
    cmd_t               cmd;
    logic               upper;
    logic               neg;
    logic [WORD_W-1:0]  val;
    logic [BCD_W-1:0]   bcd;
    logic [WORD_W-1:0]  bin;
  } dd_t;

  // Item handed to the character serialiser
  typedef struct packed {
    logic [DEC_DIGITS-1:0][3:0] dig;
    logic                       is_hex;
    logic                       upper;
    logic                       minus;
    logic [3:0]                 cnt;
  } emit_t;

  // One shift-and-add-3 step of binary to BCD conversion
  function automatic logic [BCD_W+WORD_W-1:0] dd_bit(logic [BCD_W-1:0] bcd,
                                                     logic [WORD_W-1:0] bin);
    logic [BCD_W-1:0] adj;
    logic [3:0]       d;
    adj = '0;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      d = bcd[4*k +: 4];
      adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return {adj[BCD_W-2:0], bin, 1'b0};
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] nib, logic up);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHR_ZERO + {4'h0, nib};
    end else begin
      ch = (up ? CHR_UP_A : CHR_LOW_A) + {4'h0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/i2a_ifs.sv @@
// Channel interfaces of the formatter: command input and character output.
// Plain valid/ready handshakes; no package dependency.
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] value;
  logic        upper;

  modport source (output valid, cmd, value, upper, input ready);
  modport sink   (input valid, cmd, value, upper, output ready);
endinterface

interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

@@ rtl/core/integer_to_ascii_formatter.sv @@
// Channel | dir | payload                        | transfer
// in_ch   | in  | cmd[1:0], value[31:0], upper   | valid && ready
// out_ch  | out | char_code[7:0], last           | valid && ready
//
// One character leaves per cycle while out_ch is ready; a text is 1 to 11 characters long.
// The serialiser at the end of the pipe sets this rate.
// The first character passes through these registers in order: the sign stage, which loads on the
// input transfer edge, eight BCD stages, the length stage, the serialiser and the output register.
// rst_n is synchronous; it clears all valid bits. Back-pressure on out_ch
// holds every full stage; a transfer with cmd 3 is taken and dropped.
// Depends on i2a_pkg, i2a_ifs, i2a_dd_stage, i2a_fmt and i2a_emit.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input logic clk,
  input logic rst_n,
  i2a_in_if.sink    in_ch,
  i2a_out_if.source out_ch
);

  logic s0_vld_r;
  dd_t  s0_r;
  dd_t  s0_nxt;
  logic s0_rdy;
  cmd_t in_cmd;
  logic neg;

  logic stg_vld [0:DD_STAGES];
  logic stg_rdy [0:DD_STAGES];
  dd_t  stg_dat [0:DD_STAGES];

  logic  fmt_vld;
  logic  fmt_rdy;
  emit_t fmt_dat;
  logic  emit_rdy;

  assign in_cmd = cmd_t'(in_ch.cmd);
  assign neg    = (in_cmd == CMD_DEC) && in_ch.value[WORD_W-1];

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.cmd   = in_cmd;
    s0_nxt.upper = in_ch.upper;
    s0_nxt.neg   = neg;
    s0_nxt.val   = in_ch.value;
    s0_nxt.bin   = neg ? (~in_ch.value + 32'd1) : in_ch.value;
  end

  assign s0_rdy      = !s0_vld_r || stg_rdy[0];
  assign in_ch.ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_rdy) begin
      // drop the unused command here
      s0_vld_r <= in_ch.valid && (in_cmd != CMD_RSVD);
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_ch.valid) begin
      s0_r <= s0_nxt;
    end
  end

  assign stg_vld[0] = s0_vld_r;
  assign stg_dat[0] = s0_r;

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    i2a_dd_stage u_dd (
      .clk   (clk),
      .rst_n (rst_n),
      .i_vld (stg_vld[g]),
      .i_dat (stg_dat[g]),
      .i_rdy (stg_rdy[g]),
      .o_vld (stg_vld[g+1]),
      .o_dat (stg_dat[g+1]),
      .o_rdy (stg_rdy[g+1])
    );
  end

  assign stg_rdy[DD_STAGES] = fmt_rdy;

  i2a_fmt u_fmt (
    .clk   (clk),
    .rst_n (rst_n),
    .i_vld (stg_vld[DD_STAGES]),
    .i_dat (stg_dat[DD_STAGES]),
    .i_rdy (fmt_rdy),
    .o_vld (fmt_vld),
    .o_dat (fmt_dat),
    .o_rdy (emit_rdy)
  );

  i2a_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_vld  (fmt_vld),
    .i_dat  (fmt_dat),
    .i_rdy  (emit_rdy),
    .o_vld  (out_ch.valid),
    .o_char (out_ch.char_code),
    .o_last (out_ch.last),
    .o_rdy  (out_ch.ready)
  );

endmodule

@@ rtl/core/i2a_dd_stage.sv @@
// One pipe stage of the binary to BCD converter: DD_BITS shift-add-3 steps.
// Uses i2a_pkg for the item type and the step function.
module i2a_dd_stage
  import i2a_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic i_vld,
  input  dd_t  i_dat,
  output logic i_rdy,
  output logic o_vld,
  output dd_t  o_dat,
  input  logic o_rdy
);

  logic vld_r;
  dd_t  dat_r;
  dd_t  dat_nxt;

  always_comb begin
    dat_nxt = i_dat;
    for (int s = 0; s < DD_BITS; s++) begin
      {dat_nxt.bcd, dat_nxt.bin} = dd_bit(dat_nxt.bcd, dat_nxt.bin);
    end
  end

  assign i_rdy = !vld_r || o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && i_vld) begin
      dat_r <= dat_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_dat = dat_r;

endmodule

@@ rtl/core/i2a_fmt.sv @@
// Length stage: picks the digit set and counts significant digits (eight for CMD_HEX8).
// Uses i2a_pkg for the item types and command codes.
module i2a_fmt
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  i_vld,
  input  dd_t   i_dat,
  output logic  i_rdy,
  output logic  o_vld,
  output emit_t o_dat,
  input  logic  o_rdy
);

  logic  vld_r;
  emit_t dat_r;
  emit_t dat_nxt;

  always_comb begin
    dat_nxt        = '0;
    dat_nxt.upper  = i_dat.upper;
    dat_nxt.minus  = i_dat.neg;
    dat_nxt.cnt    = 4'd1;
    if (i_dat.cmd == CMD_DEC) begin
      dat_nxt.is_hex = 1'b0;
      dat_nxt.dig    = i_dat.bcd;
      // highest non-zero digit sets the length, one digit at least
      for (int k = 1; k < DEC_DIGITS; k++) begin
        if (i_dat.bcd[4*k +: 4] != 4'h0) begin
          dat_nxt.cnt = 4'(k + 1);
        end
      end
    end else begin
      dat_nxt.is_hex = 1'b1;
      dat_nxt.dig    = {{(BCD_W-WORD_W){1'b0}}, i_dat.val};
      if (i_dat.cmd == CMD_HEX8) begin
        dat_nxt.cnt = 4'(HEX_DIGITS);
      end else begin
        for (int k = 1; k < HEX_DIGITS; k++) begin
          if (i_dat.val[4*k +: 4] != 4'h0) begin
            dat_nxt.cnt = 4'(k + 1);
          end
        end
      end
    end
  end

  assign i_rdy = !vld_r || o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && i_vld) begin
      dat_r <= dat_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_dat = dat_r;

endmodule

@@ rtl/core/i2a_emit.sv @@
// Character serialiser: sends the minus sign if there is one, then digits most significant
// first, one per cycle while the output is not stalled, through a registered output. Uses i2a_pkg.
module i2a_emit
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  i_vld,
  input  emit_t i_dat,
  output logic  i_rdy,
  output logic  o_vld,
  output logic [7:0] o_char,
  output logic  o_last,
  input  logic  o_rdy
);

  logic       busy_r;
  emit_t      e_r;
  logic       out_vld_r;
  logic [7:0] char_r;
  logic       last_r;

  logic       fire;
  logic       done;
  logic [3:0] idx;
  logic [3:0] nib;
  logic [7:0] char_nxt;

  assign fire = busy_r && (!out_vld_r || o_rdy);
  assign idx  = e_r.cnt - 4'd1;
  assign nib  = e_r.dig[idx];
  assign done = fire && !e_r.minus && (e_r.cnt == 4'd1);

  always_comb begin
    if (e_r.minus) begin
      char_nxt = CHR_MINUS;
    end else begin
      char_nxt = digit_char(nib, e_r.upper && e_r.is_hex);
    end
  end

  // take the next item in the cycle the last character enters the output register
  assign i_rdy = !busy_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (i_rdy) begin
        busy_r <= i_vld;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (o_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && i_vld) begin
      e_r <= i_dat;
    end else if (fire) begin
      if (e_r.minus) begin
        e_r.minus <= 1'b0;
      end else begin
        e_r.cnt <= idx;
      end
    end
    if (fire) begin
      char_r <= char_nxt;
      last_r <= done;
    end
  end

  assign o_vld  = out_vld_r;
  assign o_char = char_r;
  assign o_last = last_r;

endmodule

@@ rtl/core/i2a_chk.sv @@
// Port-level checker for the formatter, bound to the top level.
// Depends on assert_macros.svh, i2a_pkg and the top level's channel ports.
`include "assert_macros.svh"

module i2a_chk
  import i2a_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_code,
  input logic       out_last
);

  `ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid)
  `ASSERT_CLK(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
  `ASSERT_CLK(a_minus_not_last, out_valid && (out_char_code == CHR_MINUS) |-> !out_last)
  `ASSERT_CLK(a_minus_then_digit, out_valid && out_ready && (out_char_code == CHR_MINUS) |=> !out_valid || (out_char_code != CHR_MINUS))

endmodule

bind integer_to_ascii_formatter i2a_chk u_i2a_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last      (out_ch.last)
);

@@ verif/integer_to_ascii_formatter_checker.sv @@
`timescale 1ns / 100ps
// Character stream checker for the integer to ASCII formatter.
// Watches both channels and predicts the text of every accepted word.
// Depends on i2a_pkg.
module i2a_text_checker
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_value,
  input  logic        in_upper,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char_code,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_chars
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int         mismatch_total = 0;
  int         pending_total  = 0;

  assign fail_count    = mismatch_total;
  assign pending_chars = pending_total;

  task automatic report_mismatch(input string what);
    $display("%0t ns checker: %s", $time, what);
    mismatch_total++;
  endtask

  // Build the text of one word and queue its characters, last one flagged.
  function automatic void predict_text(cmd_t cmd, logic [31:0] word, logic up);
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic [31:0] t;
    logic [3:0]  nib;
    int          nd;
    char_beat_t  beat;
    case (cmd)
      CMD_DEC: begin
        mag = word[31] ? (~word + 32'd1) : word;
        do begin
          text.push_front(8'h30 + 8'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 32'd0);
        if (word[31]) text.push_front("-");
      end
      CMD_HEX, CMD_HEX8: begin
        nd = 1;
        if (cmd == CMD_HEX8) begin
          nd = 8;
        end else begin
          t = word;
          while (t >= 32'd16) begin
            t = t >> 4;
            nd++;
          end
        end
        for (int k = 0; k < nd; k++) begin
          nib = 4'(word >> (4 * (nd - 1 - k)));
          if (nib < 4'd10) text.push_back(8'h30 + {4'h0, nib});
          else text.push_back((up ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10);
        end
      end
      default: ;  // reserved command: dropped, nothing to expect
    endcase
    foreach (text[k]) begin
      beat.code = text[k];
      beat.last = (k == text.size() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      // Outputs first: a character can never belong to a word taken this edge.
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h last=%0b with nothing pending",
                                    out_char_code, out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code)
            report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                      out_char_code, want.code));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b on char 0x%02h, wanted %0b",
                                      out_last, out_char_code, want.last));
        end
      end
      if (in_valid && in_ready) predict_text(cmd_t'(in_cmd), in_value, in_upper);
    end
    pending_total = expected_chars.size();
  end

endmodule

@@ verif/integer_to_ascii_formatter_test.sv @@
`timescale 1ns / 100ps
// Top of the formatter testbench: clock, reset, word stimulus and verdict.
// Depends on i2a_pkg, i2a_ifs, the formatter RTL and i2a_text_checker.
module integer_to_ascii_formatter_test;
  import i2a_pkg::*;

  localparam int RANDOM_WORDS = 225;
  localparam int IDLE_LIMIT   = 2000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_chars;
  int   burst_left = 0;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();

  integer_to_ascii_formatter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  i2a_text_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_cmd        (in_ch.cmd),
    .in_value      (in_ch.value),
    .in_upper      (in_ch.upper),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last),
    .fail_count    (fail_count),
    .pending_chars (pending_chars)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one word; open a fresh burst after a random gap when the last one is spent.
  task automatic send_word(cmd_t cmd, logic [31:0] word, logic up);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= word;
    in_ch.upper <= up;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Receiver: switch between always ready, coin-flip stalls and a sparse pattern.
  initial begin
    int mode;
    int mode_left;
    int tick;
    out_ch.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (tick % 5 == 0);
      endcase
    end
  end

  // Watchdog: give up once nothing has moved for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int          sent;
    int          r;
    cmd_t        cmd;
    logic [31:0] word;
    logic [31:0] pow10;
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_DEC;
    in_ch.value = 32'd0;
    in_ch.upper = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, sign edges, most negative, digit-count edges, case, padding.
    send_word(CMD_DEC,  32'd0,          1'b0);
    send_word(CMD_DEC,  32'd1,          1'b0);
    send_word(CMD_DEC,  32'hFFFF_FFFF,  1'b0);
    send_word(CMD_DEC,  32'h7FFF_FFFF,  1'b0);
    send_word(CMD_DEC,  32'h8000_0000,  1'b0);
    send_word(CMD_DEC,  32'h8000_0001,  1'b1);
    send_word(CMD_DEC,  32'd9,          1'b0);
    send_word(CMD_DEC,  32'd10,         1'b0);
    send_word(CMD_DEC,  32'd1000000000, 1'b0);
    send_word(CMD_DEC,  32'd4294967295 - 32'd9, 1'b1);  // decimal ignores the case flag
    send_word(CMD_DEC,  32'd123456789,  1'b1);
    send_word(CMD_HEX,  32'd0,          1'b0);
    send_word(CMD_HEX,  32'h0000_000F,  1'b0);
    send_word(CMD_HEX,  32'h0000_0010,  1'b1);
    send_word(CMD_HEX,  32'h00AB_CDEF,  1'b1);
    send_word(CMD_HEX,  32'hFFFF_FFFF,  1'b0);
    send_word(CMD_HEX,  32'hFFFF_FFFF,  1'b1);
    send_word(CMD_HEX,  32'h8000_0000,  1'b0);
    send_word(CMD_HEX8, 32'd0,          1'b0);
    send_word(CMD_HEX8, 32'hDEAD_BEEF,  1'b0);
    send_word(CMD_HEX8, 32'hDEAD_BEEF,  1'b1);
    send_word(CMD_HEX8, 32'h0000_00A5,  1'b1);
    send_word(CMD_RSVD, 32'h1234_5678,  1'b0);
    send_word(CMD_RSVD, 32'hFFFF_FFFF,  1'b1);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r   = $urandom_range(0, 19);
      cmd = (r == 0) ? CMD_RSVD : cmd_t'(r % 3);
      case ($urandom_range(0, 5))
        0: word = $urandom;
        1: word = $urandom >> $urandom_range(0, 31);
        2: word = $urandom_range(0, 20);
        3: word = 32'd0 - $urandom_range(1, 1000);
        4: begin
          pow10 = 32'd1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
          word = pow10 + $urandom_range(0, 2) - 32'd1;
          if ($urandom_range(0, 1) == 1) word = 32'd0 - word;
        end
        default: word = 32'd1 << $urandom_range(0, 31);
      endcase
      send_word(cmd, word, 1'($urandom_range(0, 1)));
      if (cmd != CMD_RSVD) sent++;
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the final transfer, drain, then watch for strays.
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_chars == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
